// ===== design/dasep_pkg.sv =====
// Package for the decimal ASCII writer with comma separators.
// Holds field widths, character codes and the sequencer state type.
// No dependencies.
package dasep_pkg;

    localparam int VALUE_W = 63;
    localparam int DIGITS  = 19;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int IDX_W   = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_STRIP = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

endpackage

// ===== design/decimal_ascii_with_separators.sv =====
// Top level: binary to decimal ASCII text with comma grouping.
// Uses dasep_pkg for widths, character codes and the state type.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------
//  in      | in  | i_valid / o_stall  | i_value[62:0]
//  out     | out | o_valid / i_stall  | o_char_code[7:0], o_last
//
// One input beat at a time: shift-and-add-3 conversion of all 63 bits, one bit per
// cycle, then leading zero digits stripped one at a time (up to 18), then the
// characters (up to 25) one at a time, each when the output slot is free. A new
// value is accepted only once the last character of the previous one is loaded.
// Synchronous active-low reset clears the sequencer and output valid.
// o_stall is high from acceptance until the last character is loaded.
module decimal_ascii_with_separators
    import dasep_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last
);

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [1:0]         r_mod, n_mod;
    logic               r_first, n_first;
    logic               r_comma, n_comma;
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         top_dig;
    logic               slot_free;
    logic               need_comma;
    logic [1:0]         mod_dec;

    assign top_dig    = r_bcd[BCD_W-1 -: 4];
    assign slot_free  = !r_ovalid || !i_stall;
    assign need_comma = !r_first && (r_idx != '0) && (r_mod == 2'd0) && !r_comma;
    assign mod_dec    = (r_mod == 2'd0) ? 2'd2 : r_mod - 2'd1;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                                r_bcd[4*d +: 4] + 4'd3 : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_mod    = r_mod;
        n_first  = r_first;
        n_comma  = r_comma;
        n_ovalid = r_ovalid && i_stall;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_idx   = IDX_W'(DIGITS - 1);
                    n_mod   = 2'((DIGITS - 1) % 3);
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (top_dig == 4'd0 && r_idx != '0) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_idx = r_idx - 1'b1;
                    n_mod = mod_dec;
                end else begin
                    n_first = 1'b1;
                    n_comma = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    if (need_comma) begin
                        n_char  = CH_COMMA;
                        n_last  = 1'b0;
                        n_comma = 1'b1;
                    end else begin
                        n_char  = CH_ZERO + CHAR_W'(top_dig);
                        n_last  = (r_idx == '0);
                        n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
                        n_first = 1'b0;
                        n_comma = 1'b0;
                        if (r_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                            n_mod = mod_dec;
                        end
                    end
                end
            end
            default: begin
                n_state  = ST_IDLE;
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_mod   <= n_mod;
        r_first <= n_first;
        r_comma <= n_comma;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// ===== test/decimal_ascii_with_separators_test.sv =====
// Testbench for decimal_ascii_with_separators: directed and random values, checked beat by beat
// against a built-in predictor of the comma-grouped decimal text. Random idling on both sides.
// Depends on dasep_pkg and the decimal_ascii_with_separators RTL.
`timescale 1ns / 1ps

module decimal_ascii_with_separators_test;
    import dasep_pkg::*;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last;

    t_char_beat expected_chars[$];
    int         mismatches = 0;
    bit         full_rate  = 1'b0;

    decimal_ascii_with_separators u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Expected text: MSD first; comma before each non-leading digit whose index is 3k, k>0
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [3:0]  digit [DIGITS];
        logic [63:0] rest;
        int          count;
        t_char_beat  beat;
        rest  = {1'b0, value};
        count = 0;
        do begin
            digit[count] = 4'(rest % 64'd10);
            rest         = rest / 64'd10;
            count++;
        end while (rest != 64'd0 && count < DIGITS);
        for (int i = count - 1; i >= 0; i--) begin
            if (i != count - 1 && i != 0 && (i % 3) == 0) begin
                beat.code = CH_COMMA;
                beat.last = 1'b0;
                expected_chars.push_back(beat);
            end
            beat.code = CH_ZERO + CHAR_W'(digit[i]);
            beat.last = (i == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic logic [63:0] pow10(input int d);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < d; k++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [63:0] rnd;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        int          len;
        rnd = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = rnd;
            1: begin
                len = $urandom_range(1, VALUE_W);
                v   = rnd & ((64'd1 << len) - 64'd1);
            end
            2: begin
                len = $urandom_range(1, DIGITS);
                lo  = (len == 1) ? 64'd0 : pow10(len - 1);
                hi  = pow10(len) - 64'd1;
                if (hi > {1'b0, VALUE_MAX}) begin
                    hi = {1'b0, VALUE_MAX};
                end
                v = lo + rnd % (hi - lo + 64'd1);
            end
            default: begin
                // around a digit-count boundary, where the comma layout shifts
                len = $urandom_range(1, DIGITS - 1);
                v   = pow10(len) + 64'($urandom_range(0, 4)) - 64'd2;
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // One input beat; valid is left high so a following zero-gap beat keeps it up
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        predict_text(value);
    endtask

    task automatic test_extremes();
        send_value('0);
        send_value(VALUE_W'(1));
        send_value(VALUE_W'(9));
        send_value(VALUE_MAX);
        send_value(VALUE_MAX - VALUE_W'(1));
        send_value({1'b1, {(VALUE_W-1){1'b0}}});
        send_value(VALUE_W'({(VALUE_W+1)/2{2'b01}}));
        send_value(VALUE_W'({(VALUE_W+1)/2{2'b10}}));
        send_value(VALUE_W'(64'd123456789));
    endtask

    task automatic test_group_boundaries();
        for (int d = 1; d < DIGITS; d += 2) begin
            send_value(VALUE_W'(pow10(d) - 64'd1));
            send_value(VALUE_W'(pow10(d)));
        end
    endtask

    task automatic test_random_values();
        repeat (220) send_value(random_value());
    endtask

    task automatic test_full_rate();
        full_rate = 1'b1;
        repeat (30) send_value(random_value());
        full_rate = 1'b0;
    endtask

    // Receiver: random hold-off before each result beat
    initial begin
        int hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = full_rate ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected beat code %h last %b",
                                          o_char_code, o_last));
            end else begin
                want = expected_chars.pop_front();
                if (o_char_code !== want.code) begin
                    report_mismatch($sformatf("char_code %h, want %h", o_char_code, want.code));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %b, want %b on code %h",
                                              o_last, want.last, want.code));
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_group_boundaries();
        test_random_values();
        test_full_rate();
        i_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== decimal_ascii_with_separators.f =====
design/dasep_pkg.sv
design/decimal_ascii_with_separators.sv
test/decimal_ascii_with_separators_test.sv
